@@ design/lut2_tree_network_infer_macros.svh @@
// Assertion macros shared by the lookup-gate network RTL.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef LUT2_TREE_NETWORK_INFER_MACROS_SVH
`define LUT2_TREE_NETWORK_INFER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LUT2TN_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LUT2TN_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/lut2tn_pkg.sv @@
// Package for the lookup-gate network: beat layout, operation codes and
// elaboration-time helpers for the gate numbering. No dependencies.
`timescale 1ns / 1ps

package lut2tn_pkg;

    // Field widths of one input beat and one result beat.
    localparam int OP_W      = 1;
    localparam int GATE_W    = 7;
    localparam int TT_W      = 4;
    localparam int INBITS_W  = 8;
    localparam int OUTBITS_W = 4;

    // Stream data widths, padded to whole bytes.
    localparam int IN_USED_W   = GATE_W + TT_W + INBITS_W;
    localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUTBITS_W + 7) / 8) * 8;

    // Operation codes carried in tuser.
    localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
    localparam logic [OP_W-1:0] OP_INFER = 1'b1;

    // Input beat payload, last field in the lowest bits.
    typedef struct packed {
        logic [INBITS_W-1:0] input_bits;
        logic [TT_W-1:0]     truth_table;
        logic [GATE_W-1:0]   gate_index;
    } t_in_beat;

    // Number of tree levels over n leaves; an odd last value is dropped.
    function automatic int f_levels(input int n);
        int c;
        c = 0;
        for (int m = 1; m < 32; m++) begin
            if ((n >> m) > 0) begin
                c = c + 1;
            end
        end
        return c;
    endfunction

    // Index of the first gate of level l inside one tree over n leaves.
    function automatic int f_lvl_off(input int n, input int l);
        int s;
        s = 0;
        for (int m = 0; m < 32; m++) begin
            if (m < l) begin
                s = s + (n >> (m + 1));
            end
        end
        return s;
    endfunction

    // Gates in one whole tree over n leaves.
    function automatic int f_tree_gates(input int n);
        return f_lvl_off(n, f_levels(n));
    endfunction

endpackage

@@ design/lut2_tree_network_infer.sv @@
// Top level of the two-layer lookup-gate network: truth-table register file,
// both gate layers and the stream handshake. Depends on lut2tn_pkg and the
// assertion macro header.
//
// Channel  Dir  Signals                          Contents (lowest bit first)
// -------  ---  -------------------------------  ---------------------------------------
// s        in   s_tvalid s_tready s_tdata s_tuser  tuser: operation; tdata: gate, table, bits
// m        out  m_tvalid m_tready m_tdata          tdata: output_bits
//
// One beat is accepted per cycle unless an infer beat waits for room in the result
// register; an infer result passes the input register, then the result register.
// The whole network evaluates combinationally between those two registers.
// Reset clears the handshake state only; truth tables hold nothing until loaded.
// A stalled result holds in the result register while loads still proceed.
`timescale 1ns / 1ps
`include "lut2_tree_network_infer_macros.svh"

module lut2_tree_network_infer
    import lut2tn_pkg::*;
#(
    parameter int IN_WIDTH     = 8,
    parameter int HIDDEN_WIDTH = 8,
    parameter int OUT_WIDTH    = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // tdata: gate_index[6:0], truth_table[10:7], input_bits[18:11], zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // tuser: operation[0]
    input  logic [OP_W-1:0]        s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // tdata: output_bits[3:0], zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    // Gate numbering and register file geometry.
    localparam int L1         = f_levels(IN_WIDTH);
    localparam int L2         = f_levels(HIDDEN_WIDTH);
    localparam int T1         = f_tree_gates(IN_WIDTH);
    localparam int T2         = f_tree_gates(HIDDEN_WIDTH);
    localparam int BASE2      = HIDDEN_WIDTH * T1;
    localparam int GATE_COUNT = BASE2 + OUT_WIDTH * T2;
    localparam int IDX_W      = (GATE_COUNT > 1) ? $clog2(GATE_COUNT) : 1;
    localparam int GIX_W      = ((IDX_W > GATE_W) ? IDX_W : GATE_W) + 1;

    t_in_beat w_beat;

    logic                r_in_valid;
    logic [OP_W-1:0]     r_op;
    logic [GATE_W-1:0]   r_gate;
    logic [TT_W-1:0]     r_tt;
    logic [INBITS_W-1:0] r_bits;

    logic                 r_out_valid;
    logic [OUTBITS_W-1:0] r_out_bits;
    logic [OUTBITS_W-1:0] n_out_bits;

    logic [TT_W-1:0] r_tables [GATE_COUNT];

    logic             w_out_free;
    logic             w_in_move;
    logic             w_load_hit;
    logic [GIX_W-1:0] w_gate_ext;

    logic [IN_WIDTH-1:0]     w_in_vec;
    logic [HIDDEN_WIDTH-1:0] w_hidden;
    logic [OUT_WIDTH-1:0]    w_outs;

    assign w_beat = t_in_beat'(s_tdata[IN_USED_W-1:0]);

    // Handshake: a load never waits on the result side, an infer needs room there.
    assign w_out_free = !r_out_valid || m_tready;
    assign w_in_move  = r_in_valid && ((r_op == OP_LOAD) || w_out_free);
    assign s_tready   = !r_in_valid || w_in_move;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            r_op   <= s_tuser;
            r_gate <= w_beat.gate_index;
            r_tt   <= w_beat.truth_table;
            r_bits <= w_beat.input_bits;
        end
    end

    // Truth-table writes; an index past the last gate is dropped.
    assign w_gate_ext = GIX_W'(r_gate);
    assign w_load_hit = w_in_move && (r_op == OP_LOAD) &&
                        (w_gate_ext < GIX_W'(GATE_COUNT));

    always_ff @(posedge i_clk) begin
        if (w_load_hit) begin
            r_tables[w_gate_ext[IDX_W-1:0]] <= r_tt;
        end
    end

    // Network inputs beyond the field width read as zero.
    for (genvar i = 0; i < IN_WIDTH; i++) begin : g_in
        if (i < INBITS_W) begin : g_bit
            assign w_in_vec[i] = r_bits[i];
        end else begin : g_zero
            assign w_in_vec[i] = 1'b0;
        end
    end

    // Layer one: one gate tree over all inputs for each hidden output.
    for (genvar j = 0; j < HIDDEN_WIDTH; j++) begin : g_h
        logic [IN_WIDTH-1:0] w_lvl [L1+1];
        assign w_lvl[0] = w_in_vec;
        for (genvar l = 0; l < L1; l++) begin : g_l
            for (genvar k = 0; k < IN_WIDTH; k++) begin : g_k
                if (k < (IN_WIDTH >> (l + 1))) begin : g_gate
                    localparam logic [IDX_W-1:0] G =
                        IDX_W'(j * T1 + f_lvl_off(IN_WIDTH, l) + k);
                    assign w_lvl[l+1][k] = r_tables[G][{w_lvl[l][2*k], w_lvl[l][2*k+1]}];
                end else begin : g_zero
                    assign w_lvl[l+1][k] = 1'b0;
                end
            end
        end
        assign w_hidden[j] = w_lvl[L1][0];
    end

    // Layer two: one gate tree over all hidden values for each output.
    for (genvar j = 0; j < OUT_WIDTH; j++) begin : g_o
        logic [HIDDEN_WIDTH-1:0] w_lvl [L2+1];
        assign w_lvl[0] = w_hidden;
        for (genvar l = 0; l < L2; l++) begin : g_l
            for (genvar k = 0; k < HIDDEN_WIDTH; k++) begin : g_k
                if (k < (HIDDEN_WIDTH >> (l + 1))) begin : g_gate
                    localparam logic [IDX_W-1:0] G =
                        IDX_W'(BASE2 + j * T2 + f_lvl_off(HIDDEN_WIDTH, l) + k);
                    assign w_lvl[l+1][k] = r_tables[G][{w_lvl[l][2*k], w_lvl[l][2*k+1]}];
                end else begin : g_zero
                    assign w_lvl[l+1][k] = 1'b0;
                end
            end
        end
        assign w_outs[j] = w_lvl[L2][0];
    end

    // Outputs beyond the result field are masked; missing ones read as zero.
    for (genvar j = 0; j < OUTBITS_W; j++) begin : g_res
        if (j < OUT_WIDTH) begin : g_bit
            assign n_out_bits[j] = w_outs[j];
        end else begin : g_zero
            assign n_out_bits[j] = 1'b0;
        end
    end

    // Result register; it only advances when empty or being taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_in_move && (r_op == OP_INFER);
        end
        if (w_out_free && w_in_move && (r_op == OP_INFER)) begin
            r_out_bits <= n_out_bits;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = OUT_TDATA_W'(r_out_bits);

    // Checks on the pipeline control.
    `LUT2TN_ASSERT_IMP(a_load_never_stalls, r_in_valid && (r_op == OP_LOAD), w_in_move, "load beat stalled")
    `LUT2TN_ASSERT_NXT(a_infer_fills_result, w_in_move && (r_op == OP_INFER), r_out_valid, "infer beat lost")
    `LUT2TN_ASSERT_IMP(a_result_from_infer, $rose(r_out_valid), $past(w_in_move && (r_op == OP_INFER)), "result without infer")
    `LUT2TN_ASSERT_IMP(a_ready_when_empty, !r_in_valid, s_tready, "empty input stage not ready")

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for lut2_tree_network_infer: loads gate truth tables, streams infer
// beats with random gaps and output stalls, and checks every result against a local
// evaluation of the two gate layers. Depends on lut2tn_pkg and the RTL of the block.

module tb;
    import lut2tn_pkg::*;

    localparam int NET_IN       = 8;
    localparam int NET_HIDDEN   = 8;
    localparam int NET_OUT      = 4;
    localparam int GATES        = NET_HIDDEN * (NET_IN - 1) + NET_OUT * (NET_HIDDEN - 1);
    localparam int LAYER1_GATES = NET_HIDDEN * (NET_IN - 1);
    localparam int RANDOM_ITEMS = 1300;
    localparam int HOLD_AFTER   = 200;
    localparam int HOLD_CYCLES  = 150;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;

    // One queued input beat: operation plus the packed payload.
    typedef struct {
        logic [OP_W-1:0] op;
        t_in_beat        body;
    } net_beat_t;

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // tdata: gate_index, truth_table, input_bits, zero pad
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    // tuser: operation
    logic [OP_W-1:0]        s_tuser  = OP_LOAD;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // tdata: output_bits, zero pad
    logic [OUT_TDATA_W-1:0] m_tdata;

    net_beat_t            pending_beats[$];
    logic [OUTBITS_W-1:0] expected_outputs[$];
    logic [TT_W-1:0]      lut_bank [GATES];

    logic in_fire        = 1'b0;
    logic out_fire       = 1'b0;
    int   mismatch_count = 0;
    int   send_wait      = 0;
    int   send_calm      = 0;
    int   recv_wait      = 0;
    int   recv_calm      = 0;
    int   recv_hold      = 0;
    int   results_taken  = 0;
    bit   hold_done      = 1'b0;
    int   idle_cycles    = 0;

    lut2_tree_network_infer #(
        .IN_WIDTH    (NET_IN),
        .HIDDEN_WIDTH(NET_HIDDEN),
        .OUT_WIDTH   (NET_OUT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("%0t: MISMATCH %s", $time, what);
        mismatch_count++;
    endtask

    // Walks both layers; each output is a balanced tree of gates over the layer below,
    // gates numbered output by output, level by level, pair by pair.
    function automatic logic [OUTBITS_W-1:0] network_outputs(input logic [INBITS_W-1:0] bits);
        logic [NET_HIDDEN-1:0] level;
        logic [NET_HIDDEN-1:0] hidden;
        logic [OUTBITS_W-1:0]  result;
        int                    gate;
        int                    n;
        gate   = 0;
        hidden = '0;
        result = '0;
        for (int j = 0; j < NET_HIDDEN; j++) begin
            level = bits;
            for (n = NET_IN; n > 1; n = n / 2) begin
                for (int k = 0; k < n / 2; k++) begin
                    level[k] = lut_bank[gate][{level[2*k], level[2*k+1]}];
                    gate++;
                end
            end
            hidden[j] = level[0];
        end
        for (int j = 0; j < NET_OUT; j++) begin
            level = hidden;
            for (n = NET_HIDDEN; n > 1; n = n / 2) begin
                for (int k = 0; k < n / 2; k++) begin
                    level[k] = lut_bank[gate][{level[2*k], level[2*k+1]}];
                    gate++;
                end
            end
            result[j] = level[0];
        end
        return result;
    endfunction

    // Wait before the next beat: usually a random gap, with runs of back-to-back beats.
    function automatic int draw_wait(ref int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm_left = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    // Load beat; the input vector is don't-care and filled at random.
    function automatic void push_load(input int gate, input logic [TT_W-1:0] tt);
        net_beat_t b;
        b.op               = OP_LOAD;
        b.body.gate_index  = GATE_W'(gate);
        b.body.truth_table = tt;
        b.body.input_bits  = INBITS_W'($urandom);
        pending_beats      = {pending_beats, b};
    endfunction

    // Infer beat; gate index and table are don't-care and filled at random.
    function automatic void push_infer(input logic [INBITS_W-1:0] bits);
        net_beat_t b;
        b.op               = OP_INFER;
        b.body.gate_index  = GATE_W'($urandom);
        b.body.truth_table = TT_W'($urandom);
        b.body.input_bits  = bits;
        pending_beats      = {pending_beats, b};
    endfunction

    // Writes every gate, either all with one shared table or each with its own.
    function automatic void queue_network_load(input bit uniform);
        logic [TT_W-1:0] tt;
        tt = TT_W'($urandom);
        for (int g = 0; g < GATES; g++) begin
            push_load(g, uniform ? tt : TT_W'($urandom));
        end
    endfunction

    // Stimulus plan, reset and end of run.
    initial begin
        int planned;
        int pick;
        // Every table is written before the first infer.
        queue_network_load(1'b0);
        // Loads past the last gate must be dropped.
        push_load(GATES, 4'hF);
        push_load(127, 4'h0);
        push_infer(8'h00);
        push_infer(8'hFF);
        push_infer(8'h55);
        push_infer(8'hAA);
        push_infer(8'h01);
        push_infer(8'h80);
        // Extreme tables on the first and last gate of each layer.
        push_load(0, 4'h0);
        push_load(GATES - 1, 4'hF);
        push_load(LAYER1_GATES - 1, 4'b1000);
        push_load(LAYER1_GATES, 4'b0110);
        push_infer(8'hFF);
        push_infer(8'h00);
        push_infer(8'h0F);
        push_infer(8'hF0);
        push_load(0, 4'hF);
        push_infer(8'h00);
        // Random mix: mostly infers and in-range loads, a few whole reloads and
        // ignored loads past the end of the table store.
        planned = 0;
        while (planned < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 199);
            if (pick == 0) begin
                queue_network_load(1'($urandom_range(0, 1)));
                planned += GATES;
            end else if (pick < 120) begin
                push_infer(INBITS_W'($urandom));
                planned++;
            end else if (pick < 185) begin
                push_load($urandom_range(0, GATES - 1), TT_W'($urandom));
                planned++;
            end else begin
                push_load($urandom_range(GATES, 127), TT_W'($urandom));
                planned++;
            end
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_beats.size() != 0 || s_tvalid || expected_outputs.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_outputs.size() != 0) begin
            report_mismatch($sformatf("%0d expected outputs never arrived",
                                      expected_outputs.size()));
        end
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Sender: presents queued beats at the falling edge, with a drawn gap after each.
    always @(negedge i_clk) begin
        net_beat_t b;
        if (i_rst_n && (!s_tvalid || in_fire)) begin
            if (send_wait > 0) begin
                send_wait--;
                s_tvalid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
                b = pending_beats.pop_front();
                s_tdata  <= IN_TDATA_W'(b.body);
                s_tuser  <= b.op;
                s_tvalid <= 1'b1;
                send_wait = draw_wait(send_calm);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: draws a stall after each result, and once holds off long enough to back up
    // the block while the sender keeps offering beats.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_fire) begin
                results_taken++;
                recv_wait = draw_wait(recv_calm);
            end
            if (!hold_done && results_taken >= HOLD_AFTER) begin
                hold_done = 1'b1;
                recv_hold = HOLD_CYCLES;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_tready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Monitor: updates the table copy on load beats, predicts on infer beats and
    // compares each result beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_in_beat             seen;
        logic [OUTBITS_W-1:0] want;
        in_fire  <= i_rst_n && s_tvalid && s_tready;
        out_fire <= i_rst_n && m_tvalid && m_tready;
        if (i_rst_n && s_tvalid && s_tready) begin
            seen = s_tdata[IN_USED_W-1:0];
            if (s_tuser == OP_INFER) begin
                expected_outputs = {expected_outputs, network_outputs(seen.input_bits)};
            end else if (seen.gate_index < GATES) begin
                lut_bank[seen.gate_index] = seen.truth_table;
            end
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_outputs.size() == 0) begin
                report_mismatch($sformatf("output_bits %h with nothing expected",
                                          m_tdata[OUTBITS_W-1:0]));
            end else begin
                want = expected_outputs.pop_front();
                if (m_tdata[OUTBITS_W-1:0] !== want) begin
                    report_mismatch($sformatf("output_bits %h, expected %h",
                                              m_tdata[OUTBITS_W-1:0], want));
                end
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
